### rtl/core/bblru_pkg.sv
// Package for the byte-budget LRU cache tracker: widths, codes, controller
// state type and the controller/datapath command and status structs.
package bblru_pkg;
	localparam int unsigned ENTRIES_DEF = 32;
	localparam int unsigned KEY_W = 64;
	localparam int unsigned SIZE_W = 32;
	localparam int unsigned TOTAL_W = 48;
	localparam int unsigned OP_W = 2;
	localparam int unsigned ST_W = 3;

	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
	localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAN = 2'd2;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_MISS = 3'd1;
	localparam logic [ST_W-1:0] ST_PRESENT = 3'd2;
	localparam logic [ST_W-1:0] ST_TOO_LARGE = 3'd3;
	localparam logic [ST_W-1:0] ST_NO_ROOM = 3'd4;
	localparam logic [ST_W-1:0] ST_EMPTIED = 3'd5;
	localparam logic [ST_W-1:0] ST_FULL = 3'd6;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_ROOM,
		S_VICTIM,
		S_EVICT,
		S_REPORT,
		S_FINAL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;        // latch input item, reset scan
		logic scan_step;   // compare one entry, advance pointer
		logic scan_reset;  // restart scan pointer
		logic victim_step; // look for rank 0 entry
		logic evict;       // remove victim, decrement ranks (all lanes)
		logic promote;     // lookup hit: move entry to most recent
		logic insert;      // write new entry into free slot
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic hit;
		logic victim_found;
		logic free_ok;      // free_sp >= in_bytes
		logic too_large;
		logic full;
		logic empty;
	} stat_t;
endpackage

### rtl/core/bblru_datapath.sv
// Datapath of the LRU cache tracker: entry table, ranks, byte total, scan
// pointer and comparators. Depends on bblru_pkg.
module bblru_datapath #(
	parameter int unsigned ENTRIES = bblru_pkg::ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bblru_pkg::cmd_t                   cmd,
	output bblru_pkg::stat_t                  stat,
	input  logic [bblru_pkg::TOTAL_W-1:0]     max_bytes,
	input  logic [bblru_pkg::KEY_W-1:0]       in_key,
	input  logic [bblru_pkg::SIZE_W-1:0]      in_bytes,
	output logic [bblru_pkg::KEY_W-1:0]       ev_key,
	output logic [bblru_pkg::SIZE_W-1:0]      ev_bytes,
	output logic [bblru_pkg::SIZE_W-1:0]      hit_bytes,
	output logic [bblru_pkg::TOTAL_W-1:0]     total
);
	import bblru_pkg::*;
	localparam int unsigned IW = $clog2(ENTRIES);
	localparam int unsigned CW = $clog2(ENTRIES + 1);

	logic [KEY_W-1:0]  key_mem [ENTRIES];
	logic [SIZE_W-1:0] size_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [IW-1:0] rank_q [ENTRIES];
	logic [TOTAL_W-1:0] used_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] ptr_q;
	logic [IW-1:0] sel_q;
	logic hit_q, vfound_q;
	logic [IW-1:0] ptr_i;
	logic [IW-1:0] free_i;
	logic [TOTAL_W-1:0] free_sp;

	assign ptr_i = ptr_q[IW-1:0];
	assign free_sp = (max_bytes > used_q) ? max_bytes - used_q : '0;

	always_comb begin
		free_i = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) free_i = IW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && valid_q[ptr_i] && !hit_q) begin
			ev_key <= key_mem[ptr_i];
			ev_bytes <= size_mem[ptr_i];
		end else if (cmd.victim_step && valid_q[ptr_i] && rank_q[ptr_i] == '0 && !vfound_q) begin
			ev_key <= key_mem[ptr_i];
			ev_bytes <= size_mem[ptr_i];
		end
		if (cmd.insert) begin
			key_mem[free_i] <= in_key;
			size_mem[free_i] <= in_bytes;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
			used_q <= '0;
			cnt_q <= '0;
			ptr_q <= '0;
			sel_q <= '0;
			hit_q <= 1'b0;
			vfound_q <= 1'b0;
		end else begin
			if (cmd.load || cmd.scan_reset) begin
				ptr_q <= '0;
				hit_q <= 1'b0;
				vfound_q <= 1'b0;
			end
			if (cmd.scan_step && !hit_q) begin
				if (valid_q[ptr_i] && key_mem[ptr_i] == in_key) begin
					hit_q <= 1'b1;
					sel_q <= ptr_i;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			if (cmd.victim_step && !vfound_q) begin
				if (valid_q[ptr_i] && rank_q[ptr_i] == '0) begin
					vfound_q <= 1'b1;
					sel_q <= ptr_i;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
			if (cmd.evict) begin
				valid_q[sel_q] <= 1'b0;
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && rank_q[i] != '0) rank_q[i] <= rank_q[i] - 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
				used_q <= (used_q >= TOTAL_W'(ev_bytes)) ? used_q - TOTAL_W'(ev_bytes) : '0;
			end
			if (cmd.promote) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && rank_q[i] > rank_q[sel_q]) rank_q[i] <= rank_q[i] - 1'b1;
				end
				rank_q[sel_q] <= IW'(cnt_q - 1'b1);
			end
			if (cmd.insert) begin
				valid_q[free_i] <= 1'b1;
				rank_q[free_i] <= IW'(cnt_q);
				cnt_q <= cnt_q + 1'b1;
				used_q <= used_q + TOTAL_W'(in_bytes);
			end
		end
	end

	assign hit_bytes = ev_bytes;
	assign total = used_q;
	assign stat.scan_done = hit_q || vfound_q || (ptr_q >= CW'(ENTRIES));
	assign stat.hit = hit_q;
	assign stat.victim_found = vfound_q;
	assign stat.free_ok = free_sp >= TOTAL_W'(in_bytes);
	assign stat.too_large = TOTAL_W'(in_bytes) > max_bytes;
	assign stat.full = cnt_q >= CW'(ENTRIES);
	assign stat.empty = cnt_q == '0;
endmodule

### rtl/core/bblru_ctrl.sv
// Controller state machine of the LRU cache tracker: sequences key scan,
// eviction loop, insert and result transfers. Depends on bblru_pkg.
module bblru_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_fire,
	input  logic [bblru_pkg::OP_W-1:0]  op,
	input  logic                        allow,
	input  bblru_pkg::stat_t            stat,
	output bblru_pkg::cmd_t             cmd,
	output logic                        busy,
	output logic                        out_set,
	output logic                        out_is_ev,
	output logic                        out_hit,
	output logic [bblru_pkg::ST_W-1:0]  out_status,
	input  logic                        out_free
);
	import bblru_pkg::*;
	state_t state_q, state_d;
	logic [ST_W-1:0] st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			st_q <= ST_OK;
		end else begin
			state_q <= state_d;
			st_q <= st_d;
		end
	end

	always_comb begin
		state_d = state_q;
		st_d = st_q;
		cmd = '0;
		out_set = 1'b0;
		out_is_ev = 1'b0;
		out_hit = 1'b0;
		out_status = st_q;
		busy = state_q != S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					st_d = ST_OK;
					state_d = (op == OP_LOOKUP || op == OP_INSERT) ? S_SCAN
						: (op == OP_CLEAN) ? S_ROOM : S_FINAL;
				end
			end
			S_SCAN: begin
				if (stat.scan_done) state_d = S_DECIDE;
				else cmd.scan_step = 1'b1;
			end
			S_DECIDE: begin
				if (op == OP_LOOKUP) begin
					if (stat.hit) cmd.promote = 1'b1;
					else st_d = ST_MISS;
					state_d = S_FINAL;
				end else if (stat.hit) begin
					st_d = ST_PRESENT;
					state_d = S_FINAL;
				end else if (stat.too_large) begin
					st_d = ST_TOO_LARGE;
					state_d = S_FINAL;
				end else if (!stat.free_ok && !allow) begin
					st_d = ST_NO_ROOM;
					state_d = S_FINAL;
				end else begin
					state_d = S_ROOM;
				end
			end
			S_ROOM: begin
				cmd.scan_reset = 1'b1;
				if (stat.free_ok) begin
					if (op == OP_INSERT) begin
						if (stat.full) st_d = ST_FULL;
						else cmd.insert = 1'b1;
					end
					state_d = S_FINAL;
				end else if (stat.empty) begin
					st_d = ST_EMPTIED;
					state_d = S_FINAL;
				end else begin
					state_d = S_VICTIM;
				end
			end
			S_VICTIM: begin
				if (stat.victim_found) state_d = S_REPORT;
				else cmd.victim_step = 1'b1;
			end
			S_REPORT: begin
				if (out_free) begin
					cmd.evict = 1'b1;
					out_set = 1'b1;
					out_is_ev = 1'b1;
					state_d = S_ROOM;
				end
			end
			S_FINAL: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					out_set = 1'b1;
					out_hit = (op == OP_LOOKUP) && (st_q == ST_OK);
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### rtl/core/byte_budget_lru_cache_tracker.sv
// Top level of the byte-budget LRU cache tracker: input register, controller,
// datapath and output register. Depends on bblru_pkg, bblru_ctrl, bblru_datapath.
//
// One item at a time. A lookup or insert scans the table one entry a cycle
// for the key; each eviction finds the least recent entry by another scan
// and emits one report transfer. Results wait in an output register; the
// final result (tlast) marks the end of an item's results.
module byte_budget_lru_cache_tracker #(
	parameter int unsigned ENTRIES = bblru_pkg::ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [47:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [1:0] operation, [65:2] key, [97:66] item_bytes, [103:98] zero
	input  logic [103:0] s_tdata,
	// allow_eviction
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [63:0] evicted_key, [95:64] evicted_bytes, [98:96] status,
	// [130:99] found_bytes, [178:131] total_bytes, [183:179] zero
	output logic [183:0] m_tdata,
	// is_eviction
	output logic         m_tuser,
	output logic         m_tlast
);
	import bblru_pkg::*;

	logic [TOTAL_W-1:0] max_q;
	logic [OP_W-1:0] op_q;
	logic [KEY_W-1:0] key_q;
	logic [SIZE_W-1:0] bytes_q;
	logic allow_q;
	logic in_fire, busy, out_set, out_is_ev, out_hit, out_free;
	logic [ST_W-1:0] out_status;
	cmd_t cmd;
	stat_t stat;
	logic [KEY_W-1:0] ev_key;
	logic [SIZE_W-1:0] ev_bytes, hit_bytes;
	logic [TOTAL_W-1:0] total;
	logic [TOTAL_W-1:0] total_nx;

	assign s_tready = !busy;
	assign in_fire = s_tvalid && s_tready;
	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_q <= '0;
		else if (cfg_we) max_q <= cfg_wdata;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q <= s_tdata[1:0];
			key_q <= s_tdata[65:2];
			bytes_q <= s_tdata[97:66];
			allow_q <= s_tuser;
		end
	end

	bblru_ctrl u_ctrl (
		.clk, .arst_n, .in_fire,
		.op(busy ? op_q : s_tdata[1:0]),
		.allow(allow_q), .stat, .cmd, .busy, .out_set, .out_is_ev, .out_hit,
		.out_status, .out_free
	);

	bblru_datapath #(.ENTRIES(ENTRIES)) u_dp (
		.clk, .arst_n, .cmd, .stat, .max_bytes(max_q), .in_key(key_q),
		.in_bytes(bytes_q), .ev_key, .ev_bytes, .hit_bytes, .total
	);

	assign total_nx = (total >= TOTAL_W'(ev_bytes)) ? total - TOTAL_W'(ev_bytes) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (out_set) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_set) begin
			m_tuser <= out_is_ev;
			m_tlast <= !out_is_ev;
			m_tdata[183:179] <= '0;
			m_tdata[63:0] <= out_is_ev ? ev_key : '0;
			m_tdata[95:64] <= out_is_ev ? ev_bytes : '0;
			m_tdata[98:96] <= out_is_ev ? ST_OK : out_status;
			m_tdata[130:99] <= out_hit ? hit_bytes : '0;
			m_tdata[178:131] <= out_is_ev ? total_nx : total;
		end
	end
endmodule

### bench/tb_top.sv
// Self-checking bench for byte_budget_lru_cache_tracker: directed and random
// lookup/insert/clean traffic checked against an in-bench LRU table predictor.
// Depends on bblru_pkg and the RTL top level only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bblru_pkg::*;

	localparam int unsigned NSLOT = ENTRIES_DEF;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam logic [47:0] BUDGET_MAX = 48'hFFFF_FFFF_FFFF;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic               is_ev;
		logic [KEY_W-1:0]   ekey;
		logic [SIZE_W-1:0]  ebytes;
		logic [ST_W-1:0]    status;
		logic [SIZE_W-1:0]  found;
		logic [TOTAL_W-1:0] total;
		logic               last;
	} cache_result_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [47:0] cfg_wdata;
	logic s_tvalid, s_tready, s_tuser;
	logic [103:0] s_tdata;
	logic m_tvalid, m_tready, m_tuser, m_tlast;
	logic [183:0] m_tdata;

	// predictor state
	logic [KEY_W-1:0]   tbl_key [NSLOT];
	logic [SIZE_W-1:0]  tbl_bytes [NSLOT];
	logic               tbl_valid [NSLOT];
	logic [5:0]         tbl_rank [NSLOT];
	logic [TOTAL_W-1:0] used_total;
	logic [47:0]        budget;

	cache_result_t expected_results[$];
	logic [KEY_W-1:0] key_pool[40];
	int errors = 0;
	int burst_left = 0;
	int hold_reqs = 0, holds_done = 0, hold_cnt = 0;
	int rx_mode = 0, rx_phase = 0;
	int idle_cycles = 0;

	byte_budget_lru_cache_tracker u_dut (
		.clk, .arst_n, .cfg_we, .cfg_wdata,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	function automatic logic [47:0] room_left();
		return (budget > used_total) ? budget - used_total : 48'd0;
	endfunction

	function automatic int live_entries();
		int c = 0;
		for (int i = 0; i < NSLOT; i++) if (tbl_valid[i]) c++;
		return c;
	endfunction

	function automatic int find_entry(logic [KEY_W-1:0] k);
		for (int i = 0; i < NSLOT; i++) if (tbl_valid[i] && tbl_key[i] == k) return i;
		return -1;
	endfunction

	function automatic void push_result(logic ev, logic [KEY_W-1:0] k, logic [SIZE_W-1:0] b,
			logic [ST_W-1:0] st, logic [SIZE_W-1:0] f, logic lst);
		cache_result_t r;
		r.is_ev = ev; r.ekey = k; r.ebytes = b; r.status = st;
		r.found = f; r.total = used_total; r.last = lst;
		expected_results = {expected_results, r};
	endfunction

	// evict least recent entries until need bytes are free; 0 if table empties first
	function automatic bit free_up(logic [SIZE_W-1:0] need);
		int victim;
		while (room_left() < {16'd0, need}) begin
			victim = -1;
			for (int i = 0; i < NSLOT; i++)
				if (victim < 0 && tbl_valid[i] && tbl_rank[i] == 0) victim = i;
			if (victim < 0) return 0;
			tbl_valid[victim] = 0;
			for (int i = 0; i < NSLOT; i++)
				if (tbl_valid[i] && tbl_rank[i] > 0) tbl_rank[i]--;
			used_total = (used_total >= tbl_bytes[victim]) ?
				used_total - tbl_bytes[victim] : '0;
			push_result(1'b1, tbl_key[victim], tbl_bytes[victim], ST_OK, '0, 1'b0);
		end
		return 1;
	endfunction

	function automatic void predict_cache(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [SIZE_W-1:0] b, logic allow);
		logic [ST_W-1:0] st = ST_OK;
		logic [SIZE_W-1:0] found = '0;
		int idx, cnt, slot;
		logic [5:0] r;
		case (op)
			OP_LOOKUP: begin
				idx = find_entry(k);
				if (idx < 0) st = ST_MISS;
				else begin
					r = tbl_rank[idx];
					cnt = live_entries();
					for (int i = 0; i < NSLOT; i++)
						if (tbl_valid[i] && tbl_rank[i] > r) tbl_rank[i]--;
					tbl_rank[idx] = 6'(cnt - 1);
					found = tbl_bytes[idx];
				end
			end
			OP_INSERT: begin
				if (find_entry(k) >= 0) st = ST_PRESENT;
				else if ({16'd0, b} > budget) st = ST_TOO_LARGE;
				else if (room_left() < {16'd0, b} && !allow) st = ST_NO_ROOM;
				else if (!free_up(b)) st = ST_EMPTIED;
				else begin
					cnt = live_entries();
					if (cnt >= NSLOT) st = ST_FULL;
					else begin
						slot = -1;
						for (int i = 0; i < NSLOT; i++) if (slot < 0 && !tbl_valid[i]) slot = i;
						tbl_valid[slot] = 1; tbl_key[slot] = k; tbl_bytes[slot] = b;
						tbl_rank[slot] = 6'(cnt);
						used_total = used_total + b;
					end
				end
			end
			OP_CLEAN: if (!free_up(b)) st = ST_EMPTIED;
			default: ;
		endcase
		push_result(1'b0, '0, '0, st, found, 1'b1);
	endfunction

	task automatic send_item(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
			logic [SIZE_W-1:0] b, logic allow);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, b, k, op};
		s_tuser <= allow;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_cache(op, k, b, allow);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (NSLOT + 10) @(posedge clk);
	endtask

	task automatic set_budget(logic [47:0] v);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		budget = v;
	endtask

	task automatic test_basic_ops();
		set_budget(48'd1000);
		send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b0);
		send_item(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'd400, 1'b0);
		send_item(OP_INSERT, 64'd0, 32'd0, 1'b0);
		send_item(OP_INSERT, 64'd5, 32'd300, 1'b0);
		send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 1'b1);
		send_item(OP_INSERT, 64'd5, 32'd1, 1'b1);
		send_item(OP_INSERT, 64'd6, 32'd1001, 1'b1);
		send_item(OP_INSERT, 64'd7, 32'd500, 1'b0);
		send_item(OP_INSERT, 64'd7, 32'd500, 1'b1);
		send_item(OP_UNUSED, 64'd7, 32'hFFFF_FFFF, 1'b1);
		send_item(OP_CLEAN, 64'd0, 32'd900, 1'b0);
		send_item(OP_INSERT, 64'd8, 32'd1000, 1'b1);
		set_budget(48'd0);
		send_item(OP_INSERT, 64'd9, 32'd0, 1'b0);
		send_item(OP_CLEAN, 64'd0, 32'd1, 1'b0);
		send_item(OP_CLEAN, 64'd0, 32'hFFFF_FFFF, 1'b0);
	endtask

	task automatic test_budget_edges();
		set_budget(48'd100);
		send_item(OP_INSERT, 64'd1, 32'd60, 1'b0);
		send_item(OP_INSERT, 64'd2, 32'd40, 1'b0);
		set_budget(48'd50);
		send_item(OP_INSERT, 64'd3, 32'd50, 1'b1);
		send_item(OP_CLEAN, 64'd0, 32'd0, 1'b0);
		set_budget(BUDGET_MAX);
		send_item(OP_INSERT, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 1'b0);
	endtask

	task automatic test_full_table();
		set_budget(BUDGET_MAX);
		for (int i = 0; i <= NSLOT; i++)
			send_item(OP_INSERT, 64'h100 + i, $urandom, 1'b1);
		send_item(OP_LOOKUP, 64'h100, 32'd0, 1'b0);
		set_budget(48'd10);
		send_item(OP_INSERT, 64'h200, 32'd10, 1'b1);
	endtask

	task automatic run_random(int n, logic [47:0] bmax, int size_hi);
		logic [OP_W-1:0] op;
		logic [KEY_W-1:0] k;
		logic [SIZE_W-1:0] b;
		int pick;
		set_budget(bmax);
		hold_reqs++;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			op = (pick < 35) ? OP_LOOKUP : (pick < 85) ? OP_INSERT :
				(pick < 96) ? OP_CLEAN : OP_UNUSED;
			k = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom} :
				key_pool[$urandom_range(0, 39)];
			b = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, size_hi);
			send_item(op, k, b, $urandom_range(0, 3) != 0);
		end
	endtask

	// receiver: phases of heavy, light and no stalling, plus requested long holds
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (holds_done < hold_reqs) begin
			holds_done <= holds_done + 1;
			hold_cnt <= 400;
			m_tready <= 1'b0;
		end else begin
			rx_phase <= rx_phase + 1;
			if (rx_phase % 50 == 0) rx_mode <= $urandom_range(0, 2);
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cache_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = expected_results[0];
				expected_results.delete(0);
				if (m_tuser !== e.is_ev) begin
					$error("is_eviction exp %0h got %0h", e.is_ev, m_tuser); errors++;
				end
				if (m_tdata[63:0] !== e.ekey) begin
					$error("evicted_key exp %0h got %0h", e.ekey, m_tdata[63:0]); errors++;
				end
				if (m_tdata[95:64] !== e.ebytes) begin
					$error("evicted_bytes exp %0h got %0h", e.ebytes, m_tdata[95:64]); errors++;
				end
				if (m_tdata[98:96] !== e.status) begin
					$error("status exp %0h got %0h", e.status, m_tdata[98:96]); errors++;
				end
				if (m_tdata[130:99] !== e.found) begin
					$error("found_bytes exp %0h got %0h", e.found, m_tdata[130:99]); errors++;
				end
				if (m_tdata[178:131] !== e.total) begin
					$error("total_bytes exp %0h got %0h", e.total, m_tdata[178:131]); errors++;
				end
				if (m_tlast !== e.last) begin
					$error("last exp %0h got %0h", e.last, m_tlast); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		budget = '0;
		used_total = '0;
		for (int i = 0; i < NSLOT; i++) begin
			tbl_valid[i] = 0; tbl_rank[i] = 0; tbl_key[i] = '0; tbl_bytes[i] = '0;
		end
		for (int i = 0; i < 40; i++) key_pool[i] = {$urandom, $urandom};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_basic_ops();
		test_budget_edges();
		test_full_table();
		run_random(70, 48'd2000, 300);
		run_random(45, BUDGET_MAX, 5000);
		run_random(30, 48'd600, 150);
		wait_drained();
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
